// ===== rtl/gce_pkg.sv =====
// shared constants, command codes and controller/datapath interface types
`timescale 1ns / 1ps
`default_nettype none

package gce_pkg;

	// storage default and fixed field widths
	localparam int DEF_MAX_VERTICES = 64;
	localparam int VERTEX_W         = 6;
	localparam int CFG_W            = 7;
	localparam int VALUE_W          = 7;
	localparam int CMD_W            = 3;
	localparam int IN_TDATA_W       = 16;
	localparam int OUT_TDATA_W      = 8;

	localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 7'd64;

	// command codes
	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_ADD   = 3'd0;
	localparam cmd_t CMD_DEL   = 3'd1;
	localparam cmd_t CMD_CYCLE = 3'd2;
	localparam cmd_t CMD_COMP  = 3'd3;
	localparam cmd_t CMD_REACH = 3'd4;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic rd_a;
		logic wr_a;
		logic rd_b;
		logic wr_b;
		logic fetch;
		logic expand;
		logic finish;
	} gce_ctrl_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic in_ignore;
		logic in_bad;
		logic in_edge;
		logic walk_more;
		logic out_free;
	} gce_stat_t;

endpackage

`default_nettype wire

// ===== rtl/gce_ctrl.sv =====
// command sequencer for edge updates and graph walks
`timescale 1ns / 1ps
`default_nettype none

module gce_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  gce_pkg::gce_stat_t  stat,
	output logic                in_ready,
	output gce_pkg::gce_ctrl_t  ctrl
);
	import gce_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_WR_A,
		ST_RD_B,
		ST_WR_B,
		ST_FETCH,
		ST_EXPAND,
		ST_DONE
	} state_t;

	state_t state_q;

	// new command taken only between commands
	assign in_ready = (state_q == ST_IDLE);

	// datapath commands per state
	always_comb begin
		ctrl        = '0;
		ctrl.accept = (state_q == ST_IDLE) && in_valid;
		ctrl.rd_a   = (state_q == ST_RD_A);
		ctrl.wr_a   = (state_q == ST_WR_A);
		ctrl.rd_b   = (state_q == ST_RD_B);
		ctrl.wr_b   = (state_q == ST_WR_B);
		ctrl.fetch  = (state_q == ST_FETCH) && stat.walk_more;
		ctrl.expand = (state_q == ST_EXPAND);
		ctrl.finish = (state_q == ST_DONE) && stat.out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (stat.in_ignore) begin
							state_q <= ST_IDLE;
						end else if (stat.in_bad) begin
							state_q <= ST_DONE;
						end else if (stat.in_edge) begin
							state_q <= ST_RD_A;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_RD_A:   state_q <= ST_WR_A;
				ST_WR_A:   state_q <= ST_RD_B;
				ST_RD_B:   state_q <= ST_WR_B;
				ST_WR_B:   state_q <= ST_IDLE;
				ST_FETCH: begin
					state_q <= stat.walk_more ? ST_EXPAND : ST_DONE;
				end
				ST_EXPAND: state_q <= ST_FETCH;
				ST_DONE: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gce_dpath.sv =====
// adjacency memory, walk masks, counters and output register
`timescale 1ns / 1ps
`default_nettype none

module gce_dpath #(
	parameter int MAX_VERTICES = gce_pkg::DEF_MAX_VERTICES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gce_pkg::gce_ctrl_t            ctrl,
	output gce_pkg::gce_stat_t            stat,
	input  logic                          cfg_wr_en,
	input  logic [gce_pkg::CFG_W-1:0]     cfg_wr_data,
	input  gce_pkg::cmd_t                 in_cmd,
	input  logic [gce_pkg::VERTEX_W-1:0]  in_a,
	input  logic [gce_pkg::VERTEX_W-1:0]  in_b,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [gce_pkg::VALUE_W-1:0]   out_value,
	output logic                          out_error
);
	import gce_pkg::*;

	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int EXT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_VERTICES);

	typedef logic [MAX_VERTICES-1:0] row_t;
	typedef logic [IDX_W-1:0]        idx_t;

	// lowest set bit of a vertex mask
	function automatic idx_t lowest_set(input row_t v);
		idx_t idx;
		idx = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

	function automatic row_t onehot(input idx_t i);
		return {{(MAX_VERTICES-1){1'b0}}, 1'b1} << i;
	endfunction

	logic [CFG_W-1:0] vertex_count_q;
	logic [EXT_W-1:0] n_act;
	row_t             mask_n;

	// adjacency memory with per-row valid flags
	row_t             adj_mem [MAX_VERTICES];
	row_t             row_valid_q;
	row_t             rd_row_s1;
	logic             rd_valid_s1;
	row_t             row_data;
	logic             mem_re;
	logic             mem_we;
	idx_t             rd_addr;
	idx_t             wr_addr;
	idx_t             wr_bit;
	row_t             wr_row;

	// command and walk state
	cmd_t             cmd_q;
	idx_t             a_q;
	idx_t             b_q;
	logic             err_q;
	row_t             visited_q;
	row_t             pending_q;
	idx_t             cur_q;
	logic             root_q;
	logic             cyc_q;
	logic [CNT_W-1:0] count_q;

	logic             pend_any;
	logic             unv_any;
	row_t             unvisited;
	idx_t             pick;
	row_t             nb;
	row_t             new_v;
	row_t             old_v;
	logic             cyc_hit;
	logic             a_bad;
	logic             b_bad;
	logic [VALUE_W-1:0] result;

	logic             out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic             out_error_q;

	// vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RST;
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	// active count clamped to storage, and mask of vertices in use
	always_comb begin
		n_act = (EXT_W'(vertex_count_q) > MAX_EXT) ? MAX_EXT : EXT_W'(vertex_count_q);
		for (int i = 0; i < MAX_VERTICES; i++) begin
			mask_n[i] = (EXT_W'(i) < n_act);
		end
	end

	// incoming command decode
	assign a_bad = (EXT_W'(in_a) >= n_act);
	assign b_bad = (EXT_W'(in_b) >= n_act);

	// next vertex to expand: pending first, else a fresh root
	assign unvisited = ~visited_q & mask_n;
	assign pend_any  = |pending_q;
	assign unv_any   = |unvisited;
	assign pick      = lowest_set(pend_any ? pending_q : unvisited);

	// status toward the sequencer
	always_comb begin
		stat.in_ignore = 1'b0;
		stat.in_bad    = 1'b0;
		stat.in_edge   = 1'b0;
		unique case (in_cmd) inside
			CMD_ADD, CMD_DEL: begin
				stat.in_edge = 1'b1;
				stat.in_bad  = a_bad || b_bad;
			end
			CMD_CYCLE, CMD_COMP: begin
				stat.in_bad  = 1'b0;
			end
			CMD_REACH: begin
				stat.in_bad  = a_bad || b_bad;
			end
			default: begin
				stat.in_ignore = 1'b1;
			end
		endcase
		stat.walk_more = !((cmd_q == CMD_CYCLE) && cyc_q)
			&& (pend_any || (unv_any && (cmd_q != CMD_REACH)));
		stat.out_free  = !out_valid_q || out_ready;
	end

	// memory port selection
	assign mem_re   = ctrl.rd_a || ctrl.rd_b || ctrl.fetch;
	assign mem_we   = ctrl.wr_a || ctrl.wr_b;
	assign rd_addr  = ctrl.rd_a ? a_q : (ctrl.rd_b ? b_q : pick);
	assign wr_addr  = ctrl.wr_a ? a_q : b_q;
	assign wr_bit   = ctrl.wr_a ? b_q : a_q;
	assign row_data = rd_valid_s1 ? rd_row_s1 : '0;
	assign wr_row   = (row_data & ~onehot(wr_bit))
		| ((cmd_q == CMD_ADD) ? onehot(wr_bit) : '0);

	// adjacency rows
	always_ff @(posedge clk) begin
		if (mem_we) begin
			adj_mem[wr_addr] <= wr_row;
		end
		if (mem_re) begin
			rd_row_s1 <= adj_mem[rd_addr];
		end
	end

	// row valid flags stand in for clearing the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (mem_re) begin
				rd_valid_s1 <= row_valid_q[rd_addr];
			end
		end
	end

	// neighbors of the expanded vertex, self-loop dropped
	always_comb begin
		nb    = row_data & mask_n & ~onehot(cur_q);
		new_v = nb & ~visited_q;
		old_v = nb & visited_q;
		// a tree vertex sees only its parent already visited, a root sees none
		cyc_hit = root_q ? (|old_v) : (|(old_v & (old_v - {{(MAX_VERTICES-1){1'b0}}, 1'b1})));
	end

	// latched command fields
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			cmd_q <= in_cmd;
			a_q   <= IDX_W'(in_a);
			b_q   <= IDX_W'(in_b);
		end
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q     <= 1'b0;
			visited_q <= '0;
			pending_q <= '0;
			cur_q     <= '0;
			root_q    <= 1'b0;
			cyc_q     <= 1'b0;
			count_q   <= '0;
		end else if (ctrl.accept) begin
			err_q   <= stat.in_bad;
			cyc_q   <= 1'b0;
			count_q <= '0;
			if (in_cmd == CMD_REACH) begin
				visited_q <= onehot(IDX_W'(in_a));
				pending_q <= onehot(IDX_W'(in_a));
			end else begin
				visited_q <= '0;
				pending_q <= '0;
			end
		end else if (ctrl.fetch) begin
			visited_q <= visited_q | onehot(pick);
			pending_q <= pending_q & ~onehot(pick);
			cur_q     <= pick;
			root_q    <= !pend_any;
			if (!pend_any) begin
				count_q <= count_q + CNT_W'(1);
			end
		end else if (ctrl.expand) begin
			visited_q <= visited_q | new_v;
			pending_q <= pending_q | new_v;
			cyc_q     <= cyc_q | cyc_hit;
		end
	end

	// answer selection
	always_comb begin
		case (cmd_q)
			CMD_CYCLE: result = VALUE_W'(cyc_q);
			CMD_COMP:  result = VALUE_W'(count_q);
			CMD_REACH: result = VALUE_W'(visited_q[b_q]);
			default:   result = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_error_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
			out_value_q <= err_q ? '0 : result;
			out_error_q <= err_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_error = out_error_q;

endmodule

`default_nettype wire

// ===== rtl/graph_connectivity_engine.sv =====
// top level: undirected graph edge store with cycle, component and reach queries
//
//  channel   dir  width  contents (lowest bit first)
//  s_axis    in   16+3   tdata: vertex_a[5:0], vertex_b[11:6], zero; tuser: cmd
//  m_axis    out  8+1    tdata: value[6:0], zero; tuser: error
//  cfg       in   7      vertex_count, written when cfg_wr_en is high
//
// an edge add or delete is a read-modify-write of row a, then of row b.
// a query reads one memory row per visited vertex.
// a cycle query stops at the first cycle found; a bad vertex index answers with an error and no walk.
// reset clears all rows at once through per-row valid flags, no clearing pass.
// a finished result waits in the output register; edge commands still proceed.
`timescale 1ns / 1ps
`default_nettype none

module graph_connectivity_engine #(
	parameter int MAX_VERTICES = gce_pkg::DEF_MAX_VERTICES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [gce_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // vertex_a, vertex_b
	input  logic [gce_pkg::CMD_W-1:0]         s_axis_tuser,  // cmd
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [gce_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // value
	output logic                              m_axis_tuser,  // error
	input  logic                              cfg_wr_en,
	input  logic [gce_pkg::CFG_W-1:0]         cfg_wr_data
);
	import gce_pkg::*;

	gce_ctrl_t           ctrl;
	gce_stat_t           stat;
	logic [VALUE_W-1:0]  value;

	// sequencer
	gce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.in_ready (s_axis_tready),
		.ctrl     (ctrl)
	);

	// storage and walk datapath
	gce_dpath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_cmd      (s_axis_tuser),
		.in_a        (s_axis_tdata[VERTEX_W-1:0]),
		.in_b        (s_axis_tdata[2*VERTEX_W-1:VERTEX_W]),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_value   (value),
		.out_error   (m_axis_tuser)
	);

	assign m_axis_tdata = OUT_TDATA_W'(value);

	// at most one datapath command per cycle
	a_ctrl_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ctrl))
		else $error("more than one datapath command at once");

	// a result is loaded only when the output register is free
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwrites an untaken transfer");

	// an error result carries a zero value
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("error result with nonzero value");

	// a new command is never taken during a walk step
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> !(ctrl.fetch || ctrl.expand || ctrl.finish))
		else $error("command taken while busy");

endmodule

`default_nettype wire
